[rtl/fchg_pkg.sv]
// Shared types and codes for the footswitch chord and hold gesture recognizer.
// Used by the top level and by its port checker; no dependencies.
package fchg_pkg;

  localparam int NUM_SW  = 4;
  localparam int IDX_W   = 2;
  localparam int PAIR_W  = $clog2(NUM_SW / 2);
  localparam int TIME_W  = 32;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int CNT_W   = $clog2(NUM_SW + 1);

  typedef logic [1:0]        mode_t;
  typedef logic [2:0]        action_t;
  typedef logic [IDX_W-1:0]  sw_idx_t;
  typedef logic [TIME_W-1:0] tick_t;
  typedef logic [2:0]        reg_idx_t;

  localparam mode_t MODE_PRESS   = 2'd0;
  localparam mode_t MODE_RELEASE = 2'd1;
  localparam mode_t MODE_POLL    = 2'd2;
  localparam mode_t MODE_UNUSED  = 2'd3;

  localparam action_t ACT_PRESET = 3'd0;
  localparam action_t ACT_SCENE  = 3'd1;
  localparam action_t ACT_TUNER  = 3'd2;
  localparam action_t ACT_LAYER  = 3'd3;
  localparam action_t ACT_LOOPER = 3'd4;

  localparam reg_idx_t REG_LOOPER_SLOT  = 3'd0;
  localparam reg_idx_t REG_ENHANCED     = 3'd1;
  localparam reg_idx_t REG_SCENE_LAYER  = 3'd2;
  localparam reg_idx_t REG_CHORD_WIN    = 3'd3;
  localparam reg_idx_t REG_SCENE_WIN    = 3'd4;
  localparam reg_idx_t REG_TUNER_HOLD   = 3'd5;
  localparam reg_idx_t REG_LAYER_HOLD   = 3'd6;
  localparam reg_idx_t REG_LOOPER_HOLD  = 3'd7;

  localparam logic [2:0] SLOT_NONE = 3'b111;
  localparam logic [CNT_W-1:0] CANCEL_COUNT = CNT_W'(3);

endpackage

[rtl/footswitch_chord_hold_gesture.sv]
// Top level of the footswitch chord and hold gesture recognizer.
// Depends on fchg_pkg for types, mode, action and register codes.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per press, release or
//   poll of a footswitch, with the current tick count. Output channel
//   (out_valid / out_stall): zero or one action per request, in order.
//   Configuration is an APB-style port with eight 32-bit registers at byte
//   addresses 0, 4, ..., 28; any write also clears the gesture state and is
//   to be done only while no request is in flight.
// Pipeline and throughput:
//   An accepted request is registered in the evaluation stage, evaluated
//   there against the gesture state, and its action is then registered in
//   the result stage, which drives out_valid. One request is taken every
//   cycle unless out_stall holds a waiting action. The evaluation step is four
//   per-switch tick subtractions, a chord one, and compares with a priority pick.
// Stalls and reset:
//   While out_stall holds a waiting action, the evaluation stage holds its
//   request and in_stall rises once that stage is occupied. A synchronous
//   low rst_n empties both stages and returns registers and gesture state
//   to their defaults.
module footswitch_chord_hold_gesture (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fchg_pkg::mode_t            in_mode,
  input  fchg_pkg::sw_idx_t          in_switch_index,
  input  fchg_pkg::tick_t            in_timestamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fchg_pkg::action_t          out_action,
  output fchg_pkg::sw_idx_t          out_action_switch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fchg_pkg::CFG_AW-1:0] paddr,
  input  logic [fchg_pkg::CFG_DW-1:0] pwdata,
  output logic [fchg_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import fchg_pkg::*;

  // Configuration registers.
  logic [2:0] slot_r;
  logic       enh_r;
  logic       scene_r;
  tick_t      chord_win_r;
  tick_t      scene_win_r;
  tick_t      tuner_hold_r;
  tick_t      layer_hold_r;
  tick_t      looper_hold_r;

  // Gesture state.
  logic [NUM_SW-1:0] down_r, down_nxt;
  logic [NUM_SW-1:0] pend_r, pend_nxt;
  tick_t             ptime_r [NUM_SW];
  logic              pv_r, pv_nxt;
  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic              fired_r, fired_nxt;
  logic              cancel_r, cancel_nxt;
  tick_t             cst_r;
  logic              pt_we;
  logic              cst_we;

  // Evaluation stage.
  logic    item_v_r;
  mode_t   item_mode_r;
  sw_idx_t item_idx_r;
  tick_t   item_time_r;

  // Result stage.
  logic    out_valid_r;
  action_t out_action_r;
  sw_idx_t out_sw_r;

  logic    proc_go;
  logic    in_acc;
  logic    cfg_wr;
  logic    emit;
  action_t emit_act;
  sw_idx_t emit_sw;
  action_t sel_code;
  tick_t   window;
  tick_t   el [NUM_SW];
  tick_t   chord_el;
  logic [NUM_SW-1:0] is_slot;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign proc_go  = !out_valid_r || !out_stall;
  assign in_stall = item_v_r && !proc_go;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_action_switch = out_sw_r;

  assign sel_code = scene_r ? ACT_SCENE : ACT_PRESET;
  assign window   = enh_r ? scene_win_r : chord_win_r;
  assign chord_el = item_time_r - cst_r;

  always_comb begin
    for (int i = 0; i < NUM_SW; i++) begin
      el[i]      = item_time_r - ptime_r[i];
      is_slot[i] = !slot_r[2] && (slot_r[1:0] == IDX_W'(i));
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_LOOPER_SLOT: prdata = {{(CFG_DW-3){slot_r[2]}}, slot_r};
      REG_ENHANCED:    prdata = {{(CFG_DW-1){1'b0}}, enh_r};
      REG_SCENE_LAYER: prdata = {{(CFG_DW-1){1'b0}}, scene_r};
      REG_CHORD_WIN:   prdata = chord_win_r;
      REG_SCENE_WIN:   prdata = scene_win_r;
      REG_TUNER_HOLD:  prdata = tuner_hold_r;
      REG_LAYER_HOLD:  prdata = layer_hold_r;
      REG_LOOPER_HOLD: prdata = looper_hold_r;
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    logic              found;
    logic [CNT_W-1:0]  cnt;
    sw_idx_t           idx;
    sw_idx_t           other;
    sw_idx_t           pa;
    sw_idx_t           pb;
    logic              live;

    down_nxt   = down_r;
    pend_nxt   = pend_r;
    pv_nxt     = pv_r;
    pair_nxt   = pair_r;
    fired_nxt  = fired_r;
    cancel_nxt = cancel_r;
    pt_we      = 1'b0;
    cst_we     = 1'b0;
    emit       = 1'b0;
    emit_act   = ACT_PRESET;
    emit_sw    = '0;
    found      = 1'b0;
    cnt        = '0;
    idx        = item_idx_r;
    other      = {item_idx_r[IDX_W-1:1], ~item_idx_r[0]};
    pa         = {pair_r, 1'b0};
    pb         = {pair_r, 1'b1};
    live       = 1'b0;

    if (item_v_r && proc_go) begin
      case (item_mode_r)
        MODE_POLL: begin
          if (pv_r && !fired_r && down_r[pa] && down_r[pb] &&
              (chord_el >= ((pair_r == '0) ? tuner_hold_r : layer_hold_r))) begin
            fired_nxt = 1'b1;
            emit      = 1'b1;
            emit_act  = (pair_r == '0) ? ACT_TUNER : ACT_LAYER;
          end else begin
            // Lowest switch whose hold or pending timeout has expired wins.
            for (int i = 0; i < NUM_SW; i++) begin
              live = pend_r[i] && down_r[i];
              if (!found && live && !scene_r && is_slot[i] &&
                  el[i] >= looper_hold_r) begin
                found       = 1'b1;
                pend_nxt[i] = 1'b0;
                emit        = 1'b1;
                emit_act    = ACT_LOOPER;
                emit_sw     = IDX_W'(i);
              end else if (!found && live && !is_slot[i] && el[i] >= window) begin
                found       = 1'b1;
                pend_nxt[i] = 1'b0;
                emit        = 1'b1;
                emit_act    = sel_code;
                emit_sw     = IDX_W'(i);
              end
            end
          end
        end
        MODE_PRESS: begin
          if (!down_r[idx]) begin
            down_nxt[idx] = 1'b1;
            if (!enh_r && idx[IDX_W-1] && !(!scene_r && is_slot[idx])) begin
              // Plain mode: upper switches select at once, bar the looper slot.
              emit     = 1'b1;
              emit_act = sel_code;
              emit_sw  = idx;
            end else begin
              pt_we         = 1'b1;
              pend_nxt[idx] = 1'b1;
              for (int i = 0; i < NUM_SW; i++) begin
                cnt = cnt + CNT_W'(down_nxt[i]);
              end
              if (enh_r && cnt >= CANCEL_COUNT) begin
                pend_nxt   = '0;
                pv_nxt     = 1'b0;
                fired_nxt  = 1'b0;
                cancel_nxt = 1'b1;
              end else if (!cancel_r && down_r[other] && el[other] <= window) begin
                pv_nxt    = 1'b1;
                pair_nxt  = idx[IDX_W-1:1];
                fired_nxt = 1'b0;
                cst_we    = 1'b1;
                pend_nxt  = '0;
              end
            end
          end
        end
        MODE_RELEASE: begin
          if (down_r[idx]) begin
            down_nxt[idx] = 1'b0;
            if (cancel_r) begin
              if (down_nxt == '0) begin
                cancel_nxt = 1'b0;
              end
            end else if (pv_r) begin
              if (!down_nxt[pa] && !down_nxt[pb]) begin
                pv_nxt    = 1'b0;
                fired_nxt = 1'b0;
              end
              pend_nxt[idx] = 1'b0;
            end else if (pend_r[idx]) begin
              pend_nxt[idx] = 1'b0;
              emit          = 1'b1;
              emit_act      = sel_code;
              emit_sw       = idx;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r        <= SLOT_NONE;
      enh_r         <= 1'b0;
      scene_r       <= 1'b0;
      chord_win_r   <= '0;
      scene_win_r   <= '0;
      tuner_hold_r  <= '0;
      layer_hold_r  <= '0;
      looper_hold_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_LOOPER_SLOT: slot_r <= pwdata[2] ? SLOT_NONE : pwdata[2:0];
        REG_ENHANCED:    enh_r         <= pwdata[0];
        REG_SCENE_LAYER: scene_r       <= pwdata[0];
        REG_CHORD_WIN:   chord_win_r   <= pwdata[TIME_W-1:0];
        REG_SCENE_WIN:   scene_win_r   <= pwdata[TIME_W-1:0];
        REG_TUNER_HOLD:  tuner_hold_r  <= pwdata[TIME_W-1:0];
        REG_LAYER_HOLD:  layer_hold_r  <= pwdata[TIME_W-1:0];
        REG_LOOPER_HOLD: looper_hold_r <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      down_r   <= '0;
      pend_r   <= '0;
      pv_r     <= 1'b0;
      pair_r   <= '0;
      fired_r  <= 1'b0;
      cancel_r <= 1'b0;
    end else begin
      down_r   <= down_nxt;
      pend_r   <= pend_nxt;
      pv_r     <= pv_nxt;
      pair_r   <= pair_nxt;
      fired_r  <= fired_nxt;
      cancel_r <= cancel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      ptime_r[item_idx_r] <= item_time_r;
    end
    if (cst_we) begin
      cst_r <= item_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // An empty evaluation stage takes a request even while the result waits.
      if (!in_stall) begin
        item_v_r <= in_acc;
      end
      if (proc_go) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_mode_r <= in_mode;
      item_idx_r  <= in_switch_index;
      item_time_r <= in_timestamp;
    end
    if (proc_go && emit) begin
      out_action_r <= emit_act;
      out_sw_r     <= emit_sw;
    end
  end

endmodule

[rtl/fchg_checker.sv]
// Port-level checker for the footswitch gesture recognizer, bound to the top level.
// Depends on fchg_pkg for mode and action codes.
module fchg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input fchg_pkg::mode_t             in_mode,
  input fchg_pkg::sw_idx_t           in_switch_index,
  input fchg_pkg::tick_t             in_timestamp,
  input logic                        out_valid,
  input logic                        out_stall,
  input fchg_pkg::action_t           out_action,
  input fchg_pkg::sw_idx_t           out_action_switch,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [fchg_pkg::CFG_AW-1:0] paddr,
  input logic [fchg_pkg::CFG_DW-1:0] pwdata,
  input logic [fchg_pkg::CFG_DW-1:0] prdata,
  input logic                        pready
);
  import fchg_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // Reset empties the result stage by the next cycle.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // A new result appears only for an accepted request, after it has passed the evaluation and result stages.
  a_rise_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result appeared without a request two cycles earlier");

  // A press can only produce an immediate select.
  a_press_selects: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(in_mode, 2) == MODE_PRESS |->
      (out_action == ACT_PRESET || out_action == ACT_SCENE))
    else $error("press produced a non-select action");

  // Toggle actions always refer to switch zero.
  a_toggle_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_TUNER || out_action == ACT_LAYER) |->
      out_action_switch == '0)
    else $error("toggle action carries a nonzero switch");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_action_switch))
    else $error("stalled result changed");

endmodule

bind footswitch_chord_hold_gesture fchg_checker u_fchg_checker (.*);
